// File: rtl/core/rkga_pkg.sv
// ----------------------------------------------------------------------------
// rkga_pkg
// Shared types and codes for the radial kernel grid accumulator.
// ----------------------------------------------------------------------------
package rkga_pkg;

  localparam int N_W   = 48;  // squared, scaled distance d^2 * (L-1)^2
  localparam int H_W   = 12;  // kernel half width, Q4.8
  localparam int LSQ_W = 24;  // (L-1)^2

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_DIMS  = 2'd0,
    CFG_HALF  = 2'd1,
    CFG_LEN   = 2'd2
  } cfg_e;

  typedef struct packed {
    logic             start;
    logic [N_W-1:0]   n;
    logic [H_W-1:0]   h;
  } srch_req_t;

endpackage

// File: rtl/core/radial_kernel_grid_accumulator_core.sv
// ----------------------------------------------------------------------------
// radial_kernel_grid_accumulator_core
// Spreads complex k-space samples onto a complex grid through a kernel table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one request: kernel load,
// grid sample, cell read or grid clear. Output channel (out_valid_o /
// out_stall_i) returns one cell value per read request.
// Config writes (cfg_valid_i / cfg_ready_o) set dims mode, half width and
// kernel length; write only while the block is idle.
// One request at a time:
//   cell read: grid memory read, then the output register.
//   clear: one cell per cycle over all GRID_SIZE^3 cells.
//   sample: a setup step, then per cell of the bounding box a distance check;
//   a cell inside the radius goes through the bit-serial kernel index search
//   and the read-modify-write of the grid memory.
// Reset runs a clearing pass over the grid with in_stall_o high. A stalled
// result holds and other requests go on; a further read request waits in the
// block, with in_stall_o high, until the output register is free.
// ----------------------------------------------------------------------------
module radial_kernel_grid_accumulator_core import rkga_pkg::*; #(
  parameter int GRID_SIZE          = 32,
  parameter int KERNEL_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [12:0]        coord_x_i,
  input  logic [12:0]        coord_y_i,
  input  logic [12:0]        coord_z_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic [15:0]        density_weight_i,
  input  logic [14:0]        entry_index_i,
  input  logic [15:0]        kernel_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] cell_re_o,
  output logic signed [31:0] cell_im_o
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int KAW   = $clog2(KERNEL_TABLE_DEPTH);
  localparam int LW    = $clog2(KERNEL_TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RDOUT, S_SETUP, S_CELL_D, S_CELL_S, S_CELL_N,
    S_START, S_SRCH, S_KRD, S_KW, S_MUL, S_ACC, S_NEXT
  } state_e;

  function automatic logic [17:0] cell_range(logic [12:0] c, logic [11:0] h);
    logic [8:0] lo, hi;
    lo = (14'(c) <= 14'(h)) ? 9'd0 : 9'((14'(c) - 14'(h) + 14'd255) >> 8);
    hi = 9'((14'(c) + 14'(h)) >> 8);
    if (hi > 9'(GRID_SIZE - 1)) hi = 9'(GRID_SIZE - 1);
    return {lo, hi};
  endfunction

  function automatic logic [31:0] sat_add(logic signed [31:0] a,
                                          logic signed [18:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647)       return 32'h7fff_ffff;
    else if (s < -33'sd2147483648) return 32'h8000_0000;
    else                           return s[31:0];
  endfunction

  state_e state_q;
  logic   accept;
  logic   out_valid_q;
  logic signed [31:0] cell_re_q, cell_im_q;
  logic   rd_zero_q;
  logic [AW-1:0] clr_cnt_q;

  logic        dims_q;
  logic [11:0] half_q;
  logic [10:0] len_q;
  logic [LW-1:0] len_eff, lm1;

  logic [12:0] cx_q, cy_q, cz_q;
  logic signed [15:0] vre_q, vim_q;
  logic [15:0] w_q;
  logic [23:0] h2_q;
  logic [LSQ_W-1:0] lm1sq_q;
  logic [CW-1:0] x_q, y_q, z_q, xlo_q, xhi_q, ylo_q, yhi_q, zlo_q, zhi_q;
  logic [17:0] rng_x, rng_y, rng_z;
  logic        box_empty;
  logic signed [16:0] dx, dy, dz;
  logic [33:0] dx2_q, dy2_q, dz2_q;
  logic [35:0] d2;
  logic [23:0] d2_q;
  logic [N_W-1:0] n_q;
  logic [AW-1:0] grid_addr_q, cell_addr;
  logic [31:0] kw_q;
  logic signed [48:0] p_re_q, p_im_q, t_re, t_im;

  srch_req_t      srch_req;
  logic [KAW-1:0] ki;
  logic           srch_done;

  logic [15:0] kern_mem [KERNEL_TABLE_DEPTH];
  logic [15:0] kern_rd_q;
  logic [63:0] grid_mem [CELLS];
  logic [63:0] grid_rd_q, wr_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] rd_idx;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rd_idx      = 32'(entry_index_i);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 1'b1;
      half_q <= 12'd512;
      len_q  <= 11'd1024;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_DIMS: dims_q <= cfg_data_i[0];
        CFG_HALF: half_q <= cfg_data_i;
        CFG_LEN:  len_q  <= cfg_data_i[10:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if (16'(len_q) > 16'(KERNEL_TABLE_DEPTH)) begin
      len_eff = LW'(KERNEL_TABLE_DEPTH);
    end else begin
      len_eff = LW'(len_q);
    end
    lm1 = len_eff - LW'(1);
  end

  assign rng_x = cell_range(cx_q, half_q);
  assign rng_y = cell_range(cy_q, half_q);
  assign rng_z = dims_q ? cell_range(cz_q, half_q) : 18'd0;
  assign box_empty = (rng_x[17:9] > rng_x[8:0]) || (rng_y[17:9] > rng_y[8:0]) ||
                     (rng_z[17:9] > rng_z[8:0]);

  assign dx = $signed({1'b0, 16'({x_q, 8'h00})}) - $signed({4'b0, cx_q});
  assign dy = $signed({1'b0, 16'({y_q, 8'h00})}) - $signed({4'b0, cy_q});
  assign dz = $signed({1'b0, 16'({z_q, 8'h00})}) - $signed({4'b0, cz_q});
  assign d2 = 36'(dx2_q) + 36'(dy2_q) + 36'(dz2_q);
  assign cell_addr = AW'(z_q) * AW'(GRID_SIZE * GRID_SIZE) + AW'(y_q) * AW'(GRID_SIZE)
                   + AW'(x_q);

  assign t_re = p_re_q + 49'sd536870912;
  assign t_im = p_im_q + 49'sd536870912;

  // control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      cell_re_q   <= '0;
      cell_im_q   <= '0;
    end else begin
      if (state_q == S_RDOUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (req_e'(req_type_i))
              REQ_SAMPLE: if (half_q != '0) state_q <= S_SETUP;
              REQ_READ:   state_q <= S_RD;
              REQ_CLEAR: begin
                clr_cnt_q <= '0;
                state_q   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_RD: state_q <= S_RDOUT;
        S_RDOUT: begin
          if (!out_valid_q || !out_stall_i) begin
            cell_re_q   <= rd_zero_q ? 32'sd0 : grid_rd_q[63:32];
            cell_im_q   <= rd_zero_q ? 32'sd0 : grid_rd_q[31:0];
            state_q     <= S_IDLE;
          end
        end
        S_SETUP:  state_q <= box_empty ? S_IDLE : S_CELL_D;
        S_CELL_D: state_q <= S_CELL_S;
        S_CELL_S: state_q <= (d2 >= 36'(h2_q)) ? S_NEXT : S_CELL_N;
        S_CELL_N: state_q <= S_START;
        S_START:  state_q <= S_SRCH;
        S_SRCH:   if (srch_done) state_q <= S_KRD;
        S_KRD:    state_q <= S_KW;
        S_KW:     state_q <= S_MUL;
        S_MUL:    state_q <= S_ACC;
        S_ACC:    state_q <= S_NEXT;
        S_NEXT: begin
          if (x_q == xhi_q && y_q == yhi_q && z_q == zhi_q) state_q <= S_IDLE;
          else                                             state_q <= S_CELL_D;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cx_q      <= coord_x_i;
          cy_q      <= coord_y_i;
          cz_q      <= dims_q ? coord_z_i : 13'd0;
          vre_q     <= sample_re_i;
          vim_q     <= sample_im_i;
          w_q       <= density_weight_i;
          rd_zero_q <= (rd_idx >= 32'(CELLS));
          grid_addr_q <= AW'(rd_idx);
        end
      end
      S_SETUP: begin
        h2_q    <= half_q * half_q;
        lm1sq_q <= LSQ_W'(lm1) * LSQ_W'(lm1);
        xlo_q   <= CW'(rng_x[17:9]);
        xhi_q   <= CW'(rng_x[8:0]);
        ylo_q   <= CW'(rng_y[17:9]);
        yhi_q   <= CW'(rng_y[8:0]);
        zlo_q   <= CW'(rng_z[17:9]);
        zhi_q   <= CW'(rng_z[8:0]);
        x_q     <= CW'(rng_x[17:9]);
        y_q     <= CW'(rng_y[17:9]);
        z_q     <= CW'(rng_z[17:9]);
      end
      S_CELL_D: begin
        dx2_q       <= 34'(dx * dx);
        dy2_q       <= 34'(dy * dy);
        dz2_q       <= 34'(dz * dz);
        grid_addr_q <= cell_addr;
      end
      S_CELL_S: d2_q <= d2[23:0];
      S_CELL_N: n_q  <= N_W'(d2_q) * N_W'(lm1sq_q);
      S_KW:     kw_q <= kern_rd_q * w_q;
      S_MUL: begin
        p_re_q <= $signed({1'b0, kw_q}) * vre_q;
        p_im_q <= $signed({1'b0, kw_q}) * vim_q;
      end
      S_NEXT: begin
        if (x_q == xhi_q) begin
          x_q <= xlo_q;
          if (y_q == yhi_q) begin
            y_q <= ylo_q;
            z_q <= z_q + CW'(1);
          end else begin
            y_q <= y_q + CW'(1);
          end
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign srch_req.start = (state_q == S_START);
  assign srch_req.n     = n_q;
  assign srch_req.h     = half_q;

  rkga_ksearch #(
    .KAW(KAW)
  ) u_ksearch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (srch_req),
    .ki_o   (ki),
    .done_o (srch_done)
  );

  // kernel table
  always_ff @(posedge clk_i) begin
    if (accept && req_e'(req_type_i) == REQ_LOAD &&
        entry_index_i < 15'(KERNEL_TABLE_DEPTH)) begin
      kern_mem[KAW'(entry_index_i)] <= kernel_value_i;
    end
    kern_rd_q <= kern_mem[ki];
  end

  // grid memory, real part in the upper half
  assign wr_en   = (state_q == S_ACC) || (state_q == S_CLR);
  assign wr_addr = (state_q == S_CLR) ? clr_cnt_q : grid_addr_q;
  assign wr_data = (state_q == S_CLR) ? 64'd0 :
                   {sat_add(grid_rd_q[63:32], t_re[48:30]),
                    sat_add(grid_rd_q[31:0], t_im[48:30])};

  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    grid_rd_q <= grid_mem[grid_addr_q];
  end

  assign out_valid_o = out_valid_q;
  assign cell_re_o   = cell_re_q;
  assign cell_im_o   = cell_im_q;

endmodule

// File: rtl/core/rkga_ksearch.sv
// ----------------------------------------------------------------------------
// rkga_ksearch
// Kernel index search: largest k with (k*h)^2 <= n, one bit at a time, top bit first.
// ----------------------------------------------------------------------------
module rkga_ksearch import rkga_pkg::*; #(
  parameter int KAW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srch_req_t       req_i,
  output logic [KAW-1:0]  ki_o,
  output logic            done_o
);

  localparam int BW = $clog2(KAW);
  localparam int PW = KAW + H_W;

  logic           busy_q, phase_q, done_q;
  logic [BW-1:0]  bit_q;
  logic [KAW-1:0] ki_q, cand;
  logic [PW-1:0]  p_q;
  logic [2*PW-1:0] sq;

  assign cand = ki_q | (KAW'(1) << bit_q);
  assign sq   = p_q * p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
      ki_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        bit_q   <= BW'(KAW - 1);
        ki_q    <= '0;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (N_W'(sq) <= req_i.n) begin
            ki_q <= cand;
          end
          if (bit_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            bit_q <= bit_q - BW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !phase_q) begin
      p_q <= PW'(cand) * PW'(req_i.h);
    end
  end

  assign ki_o   = ki_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/rkga_checker.sv
// ----------------------------------------------------------------------------
// rkga_checker
// Port-level checks for the grid accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module rkga_checker import rkga_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] cell_re_o,
  input logic signed [31:0] cell_im_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cell_re_o) && $stable(cell_im_o))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("request taken during reset clearing pass");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_CLEAR |=> in_stall_o)
    else $error("request taken during grid clear");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_READ |=> in_stall_o)
    else $error("request taken before read finished");

endmodule

bind radial_kernel_grid_accumulator_core rkga_checker u_rkga_checker (.*);

// File: tb/rkga_grid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rkga_grid_checker
// Watches the config, request and result channels of the grid accumulator,
// keeps its own copy of grid, kernel table and registers, and compares each
// returned cell value against the oldest predicted one.
// ----------------------------------------------------------------------------
module rkga_grid_checker import rkga_pkg::*; #(
  parameter int GRID_SIZE          = 32,
  parameter int KERNEL_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         req_type_i,
  input  logic [12:0]        coord_x_i,
  input  logic [12:0]        coord_y_i,
  input  logic [12:0]        coord_z_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic [15:0]        density_weight_i,
  input  logic [14:0]        entry_index_i,
  input  logic [15:0]        kernel_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] cell_re_i,
  input  logic signed [31:0] cell_im_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 samples_o,
  output int                 reads_o
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  typedef struct {
    int re;
    int im;
  } cell_t;

  int          grid_re [CELLS];
  int          grid_im [CELLS];
  logic [15:0] kern [KERNEL_TABLE_DEPTH];
  logic        dims_3d;
  logic [11:0] half_w;
  logic [10:0] kern_len;
  cell_t       cell_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int sat_acc(int a, longint p);
    longint s;
    s = longint'(a) + ((p + (64'sd1 <<< 29)) >>> 30);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return int'(s);
  endfunction

  function automatic void span(int c, int h, output int lo, output int hi);
    lo = (c <= h) ? 0 : ((c - h + 255) >> 8);
    hi = (c + h) >> 8;
    if (hi > GRID_SIZE - 1) hi = GRID_SIZE - 1;
  endfunction

  function automatic void spread_sample(int cx, int cy, int cz, longint vre,
                                        longint vim, longint w);
    int     h, x0, x1, y0, y1, z0, z1, addr;
    longint len, lm1, dx, dy, dz, d2, ki, kw;
    h   = int'(half_w);
    len = longint'(kern_len);
    if (h == 0) return;
    if (len == 0) len = 1;
    if (len > KERNEL_TABLE_DEPTH) len = KERNEL_TABLE_DEPTH;
    lm1 = len - 1;
    span(cx, h, x0, x1);
    span(cy, h, y0, y1);
    if (dims_3d) begin
      span(cz, h, z0, z1);
    end else begin
      cz = 0; z0 = 0; z1 = 0;
    end
    for (int z = z0; z <= z1; z++) begin
      for (int y = y0; y <= y1; y++) begin
        for (int x = x0; x <= x1; x++) begin
          dx = x * 256 - cx;
          dy = y * 256 - cy;
          dz = z * 256 - cz;
          d2 = dx * dx + dy * dy + dz * dz;
          if (d2 < longint'(h) * h) begin
            ki = int_sqrt(d2 * lm1 * lm1) / h;
            if (ki >= len) ki = len - 1;
            kw = longint'(kern[ki]) * w;
            addr = x + y * GRID_SIZE + z * GRID_SIZE * GRID_SIZE;
            if (addr < CELLS) begin
              grid_re[addr] = sat_acc(grid_re[addr], kw * vre);
              grid_im[addr] = sat_acc(grid_im[addr], kw * vim);
            end
          end
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cell_t c;
    if (!rst_ni) begin
      foreach (grid_re[i]) begin
        grid_re[i] = 0;
        grid_im[i] = 0;
      end
      foreach (kern[i]) kern[i] = '0;
      dims_3d  = 1'b1;
      half_w   = 12'd512;
      kern_len = 11'd1024;
      cell_q.delete();
      errors_o  = 0;
      samples_o = 0;
      reads_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_DIMS: dims_3d  = cfg_data_i[0];
          CFG_HALF: half_w   = cfg_data_i;
          CFG_LEN:  kern_len = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_e'(req_type_i))
          REQ_LOAD: begin
            if (entry_index_i < KERNEL_TABLE_DEPTH) kern[entry_index_i] = kernel_value_i;
          end
          REQ_SAMPLE: begin
            spread_sample(int'(coord_x_i), int'(coord_y_i), int'(coord_z_i),
                          longint'(sample_re_i), longint'(sample_im_i),
                          longint'(density_weight_i));
            samples_o++;
          end
          REQ_READ: begin
            if (entry_index_i < CELLS) begin
              c.re = grid_re[entry_index_i];
              c.im = grid_im[entry_index_i];
            end else begin
              c.re = 0;
              c.im = 0;
            end
            cell_q.push_back(c);
          end
          REQ_CLEAR: begin
            foreach (grid_re[i]) begin
              grid_re[i] = 0;
              grid_im[i] = 0;
            end
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (cell_q.size() == 0) begin
          $display("%0t: unexpected cell result re=%0d im=%0d", $time, cell_re_i, cell_im_i);
          errors_o++;
        end else begin
          c = cell_q.pop_front();
          reads_o++;
          if (cell_re_i !== c.re) begin
            $display("%0t: cell_re expected %0d actual %0d", $time, c.re, cell_re_i);
            errors_o++;
          end
          if (cell_im_i !== c.im) begin
            $display("%0t: cell_im expected %0d actual %0d", $time, c.im, cell_im_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = cell_q.size();
  end

endmodule

// File: tb/radial_kernel_grid_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_kernel_grid_accumulator_core_tb
// Fills the kernel table, runs directed edge requests, then several register
// settings each with a burst of random loads, samples, reads and clears,
// under random request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module radial_kernel_grid_accumulator_core_tb;
  import rkga_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [11:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = '0;
  logic [12:0]        coord_x_i = '0;
  logic [12:0]        coord_y_i = '0;
  logic [12:0]        coord_z_i = '0;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic [15:0]        density_weight_i = '0;
  logic [14:0]        entry_index_i = '0;
  logic [15:0]        kernel_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] cell_re_o;
  logic signed [31:0] cell_im_o;

  int errors, pending, n_samples, n_reads;
  int burst_left = 0;
  int last_cell = 0;

  int dims[9] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
  int half[9] = '{512, 512, 256, 2048, 128, 0, 300, 1000, 640};
  int lens[9] = '{1024, 1024, 2, 1024, 0, 16, 2047, 37, 1024};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  radial_kernel_grid_accumulator_core dut (.*);

  rkga_grid_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .sample_re_i, .sample_im_i, .density_weight_i, .entry_index_i,
    .kernel_value_i, .out_valid_i(out_valid_o), .out_stall_i, .cell_re_i(cell_re_o),
    .cell_im_i(cell_im_o), .errors_o(errors), .pending_o(pending),
    .samples_o(n_samples), .reads_o(n_reads)
  );

  // receiver back-pressure: free, random, or long stretches
  always @(negedge clk_i) begin
    int mode, cnt;
    if (cnt == 0) begin
      mode = $urandom_range(0, 3);
      cnt  = $urandom_range(16, 200);
    end
    cnt--;
    case (mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 0);
      2: out_stall_i <= ($urandom_range(0, 7) == 0);
      default: out_stall_i <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic put(req_e t, int x, int y, int z, int re, int im, int w, int idx,
                     int kv);
    req_type_i       = t;
    coord_x_i        = 13'(x);
    coord_y_i        = 13'(y);
    coord_z_i        = 13'(z);
    sample_re_i      = 16'(re);
    sample_im_i      = 16'(im);
    density_weight_i = 16'(w);
    entry_index_i    = 15'(idx);
    kernel_value_i   = 16'(kv);
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic load(int idx, int kv);
    put(REQ_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, idx, kv);
  endtask

  task automatic read_cell(int idx);
    put(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, idx,
        $urandom);
  endtask

  task automatic sample(int x, int y, int z, int re, int im, int w);
    put(REQ_SAMPLE, x, y, z, re, im, w, $urandom, $urandom);
    last_cell = ((x >> 8) & 31) + ((y >> 8) & 31) * 32 + ((z >> 8) & 31) * 1024;
  endtask

  // a trailing read flushes any sample in flight; then wait for all results
  task automatic settle();
    read_cell(last_cell);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, int data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = 12'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_req();
    int r, c;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, 9) == 0 ? 8191 : 7936;
    if (r < 45) begin
      sample($urandom_range(0, c), $urandom_range(0, c), $urandom_range(0, c),
             $urandom, $urandom, $urandom);
    end else if (r < 75) begin
      read_cell($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) :
                (last_cell + $urandom_range(0, 66)) & 32767);
    end else if (r < 99) begin
      load($urandom_range(0, 32767), $urandom);
    end else begin
      put(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 1024; i++) load(i, $urandom);

    load(0, 16'hffff);
    load(1, 16'h0000);
    load(32767, 16'h1234);
    load(1024, 16'hffff);
    sample(16 * 256, 16 * 256, 16 * 256, 32767, -32768, 16'hffff);
    read_cell(16 + 16 * 32 + 16 * 1024);
    sample(16 * 256 + 77, 15 * 256 + 200, 16 * 256 + 3, -32768, 32767, 16'hffff);
    read_cell(16 + 15 * 32 + 16 * 1024);
    sample(0, 0, 0, 32767, 32767, 16'h8000);
    read_cell(0);
    sample(7936, 7936, 7936, -32768, -32768, 16'hffff);
    read_cell(32767);
    sample(8191, 8191, 8191, 12345, -54, 16'hffff);
    sample(4000, 4000, 4000, 1000, 1000, 0);
    read_cell(15 + 15 * 32 + 15 * 1024);
    put(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    read_cell(16 + 16 * 32 + 16 * 1024);
    read_cell(0);
    settle();

    for (int p = 0; p < 9; p++) begin
      cfg_write(CFG_DIMS, dims[p]);
      cfg_write(CFG_HALF, half[p]);
      cfg_write(CFG_LEN, lens[p]);
      for (int i = 0; i < 12; i++) random_req();
      settle();
    end

    $display("%0d samples spread and %0d cell reads checked over 9 register settings",
             n_samples, n_reads);
    $display("covering 2D and 3D, half widths 0 to 2048 and kernel lengths 0 to 2047");
    if (errors == 0 && pending == 0) begin
      $display("radial_kernel_grid_accumulator_core test passed");
    end else begin
      $display("radial_kernel_grid_accumulator_core test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("radial_kernel_grid_accumulator_core test failed");
    $finish;
  end

endmodule

// File: radial_kernel_grid_accumulator_core.f
rtl/core/rkga_pkg.sv
rtl/core/rkga_ksearch.sv
rtl/core/radial_kernel_grid_accumulator_core.sv
rtl/core/rkga_checker.sv
tb/rkga_grid_checker.sv
tb/radial_kernel_grid_accumulator_core_tb.sv
